// ===== src/pbe_pkg.sv =====
// Shared types and constants for the panel button, encoder and LED control unit.
package pbe_pkg;

  // Default PWM duty width
  localparam int unsigned DUTY_BITS_DEF = 8;

  // Configuration port geometry
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register reset values
  localparam logic [7:0]  STEP_SIZE_RST      = 8'd2;
  localparam logic [15:0] BLINK_PERIOD_RST   = 16'd300;
  localparam logic [7:0]  DEBOUNCE_COUNT_RST = 8'd5;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_SIZE      = 3'd0,
    CFG_BLINK_PERIOD   = 3'd1,
    CFG_DEBOUNCE_COUNT = 3'd2,
    CFG_GREEN_LEVEL    = 3'd3,
    CFG_WHITE_LEVEL    = 3'd4
  } cfg_idx_e;

  // Quadrature A:B codes, A in bit 1
  localparam logic [1:0] QUAD_00 = 2'b00;
  localparam logic [1:0] QUAD_01 = 2'b01;
  localparam logic [1:0] QUAD_11 = 2'b11;
  localparam logic [1:0] QUAD_10 = 2'b10;

  // Configuration register file contents
  typedef struct packed {
    logic [7:0]  step_size;
    logic [15:0] blink_period;
    logic [7:0]  debounce_count;
    logic [7:0]  green_level;
    logic [7:0]  white_level;
  } cfg_t;

endpackage

// ===== src/panel_button_encoder_led_control_unit.sv =====
// A poll beat accepted into the input register steps the core when the result register
// is free, and its result is held in the result register until output ready takes it.
// Throughput: one poll per cycle while results are taken; input and result registers
// each hold one beat, so input is taken while a finished result waits downstream.
// Reset (rst_ni low, asynchronous): all panel state cleared, red off, blinking off,
// configuration registers to step 2, blink period 300 ms, debounce 5, levels 0.
module panel_button_encoder_led_control_unit #(
  parameter int unsigned DUTY_BITS = pbe_pkg::DUTY_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration writes
  input  logic                            cfg_we_i,
  input  logic [pbe_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [pbe_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  // Poll beats
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            power_button_i,
  input  logic                            mode_button_i,
  input  logic                            enc_a_i,
  input  logic                            enc_b_i,
  input  logic [31:0]                     now_ms_i,
  // Result beats
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [DUTY_BITS-1:0]            duty_red_o,
  output logic [DUTY_BITS-1:0]            duty_green_o,
  output logic [DUTY_BITS-1:0]            duty_blue_o,
  output logic [DUTY_BITS-1:0]            duty_white_o
);
  import pbe_pkg::*;

  cfg_t                 cfg_q;
  logic                 s1_valid_q, out_valid_q;
  logic                 s1_power_q, s1_mode_q;
  logic [1:0]           s1_pair_q;
  logic [31:0]          s1_now_q;
  logic [DUTY_BITS-1:0] red_q, green_q, blue_q, white_q;
  logic [DUTY_BITS-1:0] red_d, green_d, blue_d, white_d;
  logic                 in_fire, s1_fire, out_free;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_size      <= STEP_SIZE_RST;
      cfg_q.blink_period   <= BLINK_PERIOD_RST;
      cfg_q.debounce_count <= DEBOUNCE_COUNT_RST;
      cfg_q.green_level    <= '0;
      cfg_q.white_level    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_STEP_SIZE:      cfg_q.step_size      <= cfg_wdata_i[7:0];
        CFG_BLINK_PERIOD:   cfg_q.blink_period   <= cfg_wdata_i;
        CFG_DEBOUNCE_COUNT: cfg_q.debounce_count <= cfg_wdata_i[7:0];
        CFG_GREEN_LEVEL:    cfg_q.green_level    <= cfg_wdata_i[7:0];
        CFG_WHITE_LEVEL:    cfg_q.white_level    <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // Handshake flow
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire)      s1_valid_q <= 1'b1;
      else if (s1_fire) s1_valid_q <= 1'b0;
      if (s1_fire)          out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_power_q <= power_button_i;
      s1_mode_q  <= mode_button_i;
      s1_pair_q  <= {enc_a_i, enc_b_i};
      s1_now_q   <= now_ms_i;
    end
  end

  pbe_core #(
    .DUTY_BITS(DUTY_BITS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (s1_fire),
    .power_i (s1_power_q),
    .mode_i  (s1_mode_q),
    .pair_i  (s1_pair_q),
    .now_i   (s1_now_q),
    .cfg_i   (cfg_q),
    .red_o   (red_d),
    .green_o (green_d),
    .blue_o  (blue_d),
    .white_o (white_d)
  );

  // Result register
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
      white_q <= white_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign duty_red_o   = red_q;
  assign duty_green_o = green_q;
  assign duty_blue_o  = blue_q;
  assign duty_white_o = white_q;

`ifndef SYNTHESIS
  // Input is only refused while a beat is held in the input register
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q)
    else $error("input refused with empty input register");

  // A held input beat survives a stalled result
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && !out_ready_i |=> s1_valid_q)
    else $error("input beat dropped under output stall");

  // A result appears only after an input beat moved forward
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("result without input beat");
`endif

endmodule

// ===== src/pbe_core.sv =====
// Panel state: button debounce, encoder tracking, blink timing and duty values.
module pbe_core #(
  parameter int unsigned DUTY_BITS = pbe_pkg::DUTY_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic                 power_i,
  input  logic                 mode_i,
  input  logic [1:0]           pair_i,
  input  logic [31:0]          now_i,
  input  pbe_pkg::cfg_t        cfg_i,
  output logic [DUTY_BITS-1:0] red_o,
  output logic [DUTY_BITS-1:0] green_o,
  output logic [DUTY_BITS-1:0] blue_o,
  output logic [DUTY_BITS-1:0] white_o
);
  import pbe_pkg::*;

  localparam int unsigned LVL_W = (DUTY_BITS > 8) ? DUTY_BITS : 8;
  localparam int unsigned SUM_W = LVL_W + 1;
  localparam logic [DUTY_BITS-1:0] DUTY_MAX = '1;

  typedef struct packed {
    logic       last;
    logic [7:0] hold;
    logic       fire;
  } db_t;

  // Debounce: count polls held high after a low reading
  function automatic db_t debounce(input logic level, input logic last,
                                   input logic [7:0] hold, input logic [7:0] cnt);
    db_t r;
    r.last = last;
    r.hold = hold;
    r.fire = 1'b0;
    if (!last && level) begin
      if (hold < cnt) r.hold = hold + 8'd1;
    end else begin
      r.hold = '0;
      r.last = level;
    end
    if (r.hold == cnt) begin
      r.last = level;
      r.fire = 1'b1;
    end
    return r;
  endfunction

  logic                 power_last_q, mode_last_q;
  logic [7:0]           power_hold_q, mode_hold_q;
  logic                 red_on_q, red_on_d;
  logic                 blink_en_q, blink_en_d;
  logic                 phase_q, phase_d;
  logic [31:0]          mark_q, mark_d;
  logic [1:0]           quad_q;
  logic [DUTY_BITS-1:0] blue_q, blue_d;

  db_t                  pwr_db, mode_db;
  logic                 fwd;
  logic [SUM_W-1:0]     blue_ext, step_ext, sum, diff;
  logic [31:0]          elapsed;
  logic [LVL_W-1:0]     green_ext, white_ext;

  // Buttons
  always_comb begin
    pwr_db     = debounce(power_i, power_last_q, power_hold_q, cfg_i.debounce_count);
    mode_db    = debounce(mode_i, mode_last_q, mode_hold_q, cfg_i.debounce_count);
    red_on_d   = red_on_q ^ pwr_db.fire;
    blink_en_d = blink_en_q ^ mode_db.fire;
  end

  // Encoder: forward steps raise blue, any other change lowers it
  always_comb begin
    fwd = ((quad_q == QUAD_00) && (pair_i == QUAD_01)) ||
          ((quad_q == QUAD_01) && (pair_i == QUAD_11)) ||
          ((quad_q == QUAD_11) && (pair_i == QUAD_10)) ||
          ((quad_q == QUAD_10) && (pair_i == QUAD_00));
    blue_ext = SUM_W'(blue_q);
    step_ext = SUM_W'(cfg_i.step_size);
    sum      = blue_ext + step_ext;
    diff     = blue_ext - step_ext;
    blue_d   = blue_q;
    if (pair_i != quad_q) begin
      if (fwd) begin
        blue_d = (sum > SUM_W'(DUTY_MAX)) ? DUTY_MAX : sum[DUTY_BITS-1:0];
      end else begin
        blue_d = (blue_ext > step_ext) ? diff[DUTY_BITS-1:0] : '0;
      end
    end
  end

  // Blink phase timing, kept while blinking is off
  always_comb begin
    elapsed = now_i - mark_q;
    phase_d = phase_q;
    mark_d  = mark_q;
    if (blink_en_d && (elapsed > 32'(cfg_i.blink_period))) begin
      phase_d = ~phase_q;
      mark_d  = now_i;
    end
  end

  // Duty values for this poll
  always_comb begin
    green_ext = LVL_W'(cfg_i.green_level);
    white_ext = LVL_W'(cfg_i.white_level);
    red_o     = red_on_d ? DUTY_MAX : '0;
    green_o   = (blink_en_d && phase_d) ? '0 : green_ext[DUTY_BITS-1:0];
    blue_o    = blue_d;
    white_o   = white_ext[DUTY_BITS-1:0];
  end

  // State update once per poll
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_last_q <= 1'b0;
      power_hold_q <= '0;
      mode_last_q  <= 1'b0;
      mode_hold_q  <= '0;
      red_on_q     <= 1'b0;
      blink_en_q   <= 1'b0;
      phase_q      <= 1'b0;
      mark_q       <= '0;
      quad_q       <= QUAD_00;
      blue_q       <= '0;
    end else if (step_i) begin
      power_last_q <= pwr_db.last;
      power_hold_q <= pwr_db.hold;
      mode_last_q  <= mode_db.last;
      mode_hold_q  <= mode_db.hold;
      red_on_q     <= red_on_d;
      blink_en_q   <= blink_en_d;
      phase_q      <= phase_d;
      mark_q       <= mark_d;
      quad_q       <= pair_i;
      blue_q       <= blue_d;
    end
  end

`ifndef SYNTHESIS
  // A completed power press flips red
  a_red_toggle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && pwr_db.fire |=> red_on_q != $past(red_on_q))
    else $error("red did not toggle on debounced press");

  // Blue only moves on an encoder change
  a_blue_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (pair_i == quad_q) |=> blue_q == $past(blue_q))
    else $error("blue moved without encoder change");

  // Phase only flips while blinking is on
  a_phase_en: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !blink_en_d |=> phase_q == $past(phase_q))
    else $error("blink phase moved while blinking off");
`endif

endmodule
